>>> rtl/svm_pkg.sv
// shared types and constants for the voice mixer
package svm_pkg;

    localparam int GAIN_BITS = 14;
    localparam int MIX_BITS  = 24;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_START  = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_RENDER = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [2:0]         voice;
        logic [15:0]        sample_addr;
        logic signed [15:0] sample_value;
        logic [15:0]        clip_base;
        logic [16:0]        clip_frames;
        logic [3:0]         clip_channels;
        logic               looping;
        logic [15:0]        gain;
        logic [23:0]        pitch_step;
        logic [31:0]        start_position;
    } in_word_t;

    typedef struct packed {
        logic [2:0]                 channel;
        logic signed [MIX_BITS-1:0] mix_sample;
        logic                       last;
        logic [7:0]                 playing_mask;
    } out_word_t;

    typedef struct packed {
        logic [15:0] base;
        logic [16:0] frames;
        logic [3:0]  channels;
        logic        loop;
        logic [15:0] gain;
        logic [23:0] step;
    } voice_param_t;

endpackage

>>> rtl/sample_voice_mixer_linear_interp_unit.sv
// multi-voice sample player and mixer with linear interpolation
// operation: write, start and stop are taken in idle; a render walks every voice
//   (a modulo pass on a position wrap; read, interpolate and scale per clip channel used)
//   and then sends out_channels words, at most MAX_OUT_CHANNELS of them
// throughput: one item at a time, a render holds the input until its last word is taken
// reset: aresetn low clears all voices to stopped and out_channels to 2
module sample_voice_mixer_linear_interp_unit #(
    parameter int NUM_VOICES       = 8,
    parameter int SAMPLE_WORDS     = 65536,
    parameter int MAX_OUT_CHANNELS = 8,
    parameter int FRAC_BITS        = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  svm_pkg::in_word_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output svm_pkg::out_word_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data
);

    localparam int AW   = $clog2(SAMPLE_WORDS);
    localparam int VW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int CIW  = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
    localparam int CW   = $clog2(MAX_OUT_CHANNELS + 1) + 1;
    localparam int PW   = 24 + FRAC_BITS;
    localparam int SW   = 8 + FRAC_BITS;
    localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int IW   = FRAC_BITS + 18;
    localparam int CTW  = IW + 17;
    localparam int ACCW = CTW + VW + 1;
    localparam int SHW  = ACCW - FRAC_BITS - svm_pkg::GAIN_BITS;

    typedef enum logic [3:0] {
        ST_IDLE, ST_VRD, ST_VEVAL, ST_MOD, ST_ROWS, ST_CHK, ST_RD0, ST_RD1,
        ST_MUL1, ST_MUL2, ST_ACC, ST_VWB, ST_OUT_LD, ST_OUT_WAIT
    } state_t;

    state_t                   state_reg;
    logic [3:0]               nch_cfg_reg;
    logic [NUM_VOICES-1:0]    playing_reg;
    logic [VW-1:0]            vk_reg;
    logic [CW-1:0]            ch_reg;
    logic [4:0]               mod_cnt_reg;
    logic [23:0]              quo_reg;
    logic [17:0]              rem_reg;
    logic [PW-1:0]            pos_reg;
    logic [15:0]              f0_reg;
    logic [FRAC_BITS-1:0]     frac_reg;
    logic [AW-1:0]            row0_reg, row1_reg;
    logic signed [15:0]       s0_reg;
    logic signed [IW-1:0]     interp_reg;
    logic signed [CTW-1:0]    prod_reg;
    logic signed [ACCW-1:0]   acc_reg [MAX_OUT_CHANNELS];
    logic                     m_valid_reg;
    svm_pkg::out_word_t       m_data_reg;

    svm_pkg::voice_param_t    vmem [NUM_VOICES];
    logic [PW-1:0]            pmem [NUM_VOICES];
    logic signed [15:0]       smem [SAMPLE_WORDS];
    svm_pkg::voice_param_t    vdat_reg;
    logic [PW-1:0]            pdat_reg;
    logic signed [15:0]       rdata_reg;

    logic [AW-1:0]  raddr;
    logic           s_acc;
    logic [4:0]     nch;
    logic [VW-1:0]  s_vidx;
    logic           s_vok;
    logic [23:0]    f0_w;
    logic [16:0]    f1_w;
    logic [31:0]    row0_w, row1_w;
    logic [PW-1:0]  step_w;
    logic [PW-1:0]  spos_w;
    logic [18:0]    mod_t;
    logic signed [SHW-1:0] sh_w;
    logic signed [svm_pkg::MIX_BITS-1:0] sat_w;
    logic [7:0]     mask_w;

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign nch = (32'(nch_cfg_reg) > MAX_OUT_CHANNELS) ? 5'(MAX_OUT_CHANNELS)
                                                       : {1'b0, nch_cfg_reg};
    assign s_vidx = VW'(s_data.voice);
    assign s_vok  = 32'(s_data.voice) < NUM_VOICES;
    assign f0_w   = pdat_reg[PW-1:FRAC_BITS];
    assign step_w = (PW'(vdat_reg.step) << SH_L) >> SH_R;
    assign spos_w = (PW'(s_data.start_position) << SH_L) >> SH_R;
    assign mod_t  = {rem_reg, quo_reg[23]};

    always_comb begin
        if (({1'b0, f0_reg} + 17'd1) >= vdat_reg.frames) begin
            f1_w = vdat_reg.loop ? 17'd0 : {1'b0, f0_reg};
        end else begin
            f1_w = {1'b0, f0_reg} + 17'd1;
        end
        row0_w = 32'(vdat_reg.base) + 32'(f0_reg) * 32'(vdat_reg.channels);
        row1_w = 32'(vdat_reg.base) + 32'(f1_w) * 32'(vdat_reg.channels);
    end

    always_comb begin
        if (state_reg == ST_IDLE) begin
            raddr = AW'(s_data.sample_addr);
        end else if (state_reg == ST_RD0) begin
            raddr = row0_reg + AW'(ch_reg);
        end else begin
            raddr = row1_reg + AW'(ch_reg);
        end
    end

    always_comb begin
        sh_w = SHW'(acc_reg[ch_reg[CIW-1:0]] >>> (FRAC_BITS + svm_pkg::GAIN_BITS));
        if (sh_w > SHW'(signed'(24'sh7FFFFF))) begin
            sat_w = 24'sh7FFFFF;
        end else if (sh_w < SHW'(signed'(-25'sd8388608))) begin
            sat_w = -24'sd8388608;
        end else begin
            sat_w = sh_w[svm_pkg::MIX_BITS-1:0];
        end
        mask_w = '0;
        for (int i = 0; i < NUM_VOICES && i < 8; i++) begin
            mask_w[i] = playing_reg[i];
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (s_acc && s_data.action == svm_pkg::ACT_WRITE) begin
            smem[raddr] <= s_data.sample_value;
        end
        rdata_reg <= smem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.action == svm_pkg::ACT_START && s_vok) begin
            vmem[s_vidx] <= '{base: s_data.clip_base, frames: s_data.clip_frames,
                              channels: s_data.clip_channels, loop: s_data.looping,
                              gain: s_data.gain, step: s_data.pitch_step};
        end
        vdat_reg <= vmem[vk_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_acc && s_data.action == svm_pkg::ACT_START && s_vok) begin
            pmem[s_vidx] <= spos_w;
        end else if (state_reg == ST_VWB) begin
            pmem[vk_reg] <= pos_reg + step_w;
        end
        pdat_reg <= pmem[vk_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            nch_cfg_reg <= 4'd2;
            playing_reg <= '0;
            m_valid_reg <= 1'b0;
            vk_reg      <= '0;
            ch_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                nch_cfg_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        case (s_data.action)
                            svm_pkg::ACT_START: if (s_vok) playing_reg[s_vidx] <= 1'b1;
                            svm_pkg::ACT_STOP:  if (s_vok) playing_reg[s_vidx] <= 1'b0;
                            svm_pkg::ACT_RENDER: begin
                                if (nch != 5'd0) begin
                                    for (int i = 0; i < MAX_OUT_CHANNELS; i++) begin
                                        acc_reg[i] <= '0;
                                    end
                                    vk_reg    <= '0;
                                    state_reg <= ST_VRD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_VRD: state_reg <= ST_VEVAL;
                ST_VEVAL: begin
                    pos_reg  <= pdat_reg;
                    f0_reg   <= f0_w[15:0];
                    frac_reg <= pdat_reg[FRAC_BITS-1:0];
                    if (!playing_reg[vk_reg] || vdat_reg.channels == 4'd0) begin
                        state_reg <= ST_VWB;
                    end else if (vdat_reg.frames == 17'd0) begin
                        playing_reg[vk_reg] <= 1'b0;
                        state_reg <= ST_VWB;
                    end else if (vdat_reg.step == 24'd0) begin
                        state_reg <= ST_VWB;
                    end else if (f0_w >= 24'(vdat_reg.frames)) begin
                        if (!vdat_reg.loop) begin
                            playing_reg[vk_reg] <= 1'b0;
                            state_reg <= ST_VWB;
                        end else begin
                            quo_reg     <= f0_w;
                            rem_reg     <= '0;
                            mod_cnt_reg <= 5'd24;
                            state_reg   <= ST_MOD;
                        end
                    end else begin
                        state_reg <= ST_ROWS;
                    end
                end
                ST_MOD: begin
                    quo_reg <= {quo_reg[22:0], 1'b0};
                    if (mod_t >= 19'(vdat_reg.frames)) begin
                        rem_reg <= 18'(mod_t - 19'(vdat_reg.frames));
                    end else begin
                        rem_reg <= mod_t[17:0];
                    end
                    mod_cnt_reg <= mod_cnt_reg - 5'd1;
                    if (mod_cnt_reg == 5'd0) begin
                        f0_reg    <= rem_reg[15:0];
                        pos_reg   <= {8'd0, rem_reg[15:0], frac_reg};
                        state_reg <= ST_ROWS;
                    end
                end
                ST_ROWS: begin
                    row0_reg  <= row0_w[AW-1:0];
                    row1_reg  <= row1_w[AW-1:0];
                    ch_reg    <= '0;
                    state_reg <= ST_CHK;
                end
                ST_CHK: begin
                    if (5'(ch_reg) < nch && 5'(ch_reg) < {1'b0, vdat_reg.channels}) begin
                        state_reg <= ST_RD0;
                    end else begin
                        state_reg <= ST_VWB;
                    end
                end
                ST_RD0: state_reg <= ST_RD1;
                ST_RD1: begin
                    s0_reg    <= rdata_reg;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    interp_reg <= (IW'(s0_reg) <<< FRAC_BITS)
                        + IW'((17'(rdata_reg) - 17'(s0_reg)) * $signed({1'b0, frac_reg}));
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    prod_reg  <= CTW'(interp_reg * $signed({1'b0, vdat_reg.gain}));
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg[ch_reg[CIW-1:0]] <= acc_reg[ch_reg[CIW-1:0]] + ACCW'(prod_reg);
                    ch_reg    <= ch_reg + CW'(1);
                    state_reg <= ST_CHK;
                end
                ST_VWB: begin
                    if (32'(vk_reg) == NUM_VOICES - 1) begin
                        ch_reg    <= '0;
                        state_reg <= ST_OUT_LD;
                    end else begin
                        vk_reg    <= vk_reg + VW'(1);
                        state_reg <= ST_VRD;
                    end
                end
                ST_OUT_LD: begin
                    m_data_reg.channel      <= ch_reg[2:0];
                    m_data_reg.mix_sample   <= sat_w;
                    m_data_reg.last         <= (5'(ch_reg) + 5'd1 == nch);
                    m_data_reg.playing_mask <= mask_w;
                    m_valid_reg             <= 1'b1;
                    state_reg               <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        ch_reg      <= ch_reg + CW'(1);
                        state_reg   <= m_data_reg.last ? ST_IDLE : ST_OUT_LD;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // a word is only shown while waiting on the sink
    a_valid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> state_reg == ST_OUT_WAIT)
        else $error("result valid outside output wait");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_data.last) |=> state_reg == ST_IDLE)
        else $error("no return to idle after last word");

    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.action == svm_pkg::ACT_STOP && s_vok)
        |=> !playing_reg[$past(s_vidx)])
        else $error("stopped voice still playing");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid_reg)
        else $error("input taken while a word is pending");

endmodule

>>> tb/sv/testbench.sv
// testbench for the multi-voice sample player and mixer
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 900;
    localparam int HOLD_CYCLES = 700;

    typedef struct {
        svm_pkg::in_word_t  w;
        bit                 typed;
        logic signed [23:0] mix0;
        logic signed [23:0] mix1;
        logic [7:0]         mask;
    } stim_row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    svm_pkg::in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    svm_pkg::out_word_t m_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [3:0] cfg_data = '0;

    // mixer model state
    shortint        smem[65536];
    bit             swritten[65536];
    bit             vplay[8];
    longint unsigned vpos[8];
    longint unsigned vstep[8];
    int unsigned    vgain[8];
    int unsigned    vbase[8];
    int unsigned    vframes[8];
    int unsigned    vchs[8];
    bit             vloop[8];
    int unsigned    out_chans = 2;

    svm_pkg::out_word_t mix_q[$];
    int errors = 0;
    int words_checked = 0;
    int renders = 0;
    int cycles = 0;
    bit calm = 0;
    bit hold_req = 0;

    sample_voice_mixer_linear_interp_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void model_item(svm_pkg::in_word_t w);
        longint acc[8];
        longint unsigned pos, f0, f1, frac, frames;
        longint s0, s1, interp, m;
        int unsigned nch, a0, a1;
        logic [7:0] mask;
        svm_pkg::out_word_t o;
        case (w.action)
            svm_pkg::ACT_WRITE: begin
                smem[w.sample_addr] = w.sample_value;
                swritten[w.sample_addr] = 1'b1;
            end
            svm_pkg::ACT_START: begin
                vbase[w.voice] = 32'(w.clip_base);
                vframes[w.voice] = 32'(w.clip_frames);
                vchs[w.voice] = 32'(w.clip_channels);
                vloop[w.voice] = w.looping;
                vgain[w.voice] = 32'(w.gain);
                vstep[w.voice] = 64'(w.pitch_step);
                vpos[w.voice] = 64'(w.start_position);
                vplay[w.voice] = 1'b1;
            end
            svm_pkg::ACT_STOP: vplay[w.voice] = 1'b0;
            svm_pkg::ACT_RENDER: begin
                nch = (out_chans > 8) ? 8 : out_chans;
                if (nch == 0) return;
                renders++;
                foreach (acc[c]) acc[c] = 0;
                for (int k = 0; k < 8; k++) begin
                    if (!vplay[k] || vchs[k] == 0) continue;
                    frames = 64'(vframes[k]);
                    if (frames == 0) begin
                        vplay[k] = 1'b0;
                        continue;
                    end
                    if (vstep[k] == 0) continue;
                    pos = vpos[k];
                    f0 = pos >> 16;
                    if (f0 >= frames) begin
                        if (!vloop[k]) begin
                            vplay[k] = 1'b0;
                            continue;
                        end
                        pos = pos % (frames << 16);
                        f0 = pos >> 16;
                    end
                    frac = pos & 64'hFFFF;
                    f1 = f0 + 1;
                    if (f1 >= frames) f1 = vloop[k] ? 0 : f0;
                    for (int c = 0; c < nch; c++) begin
                        if (c >= vchs[k]) continue;
                        a0 = 32'((64'(vbase[k]) + f0 * 64'(vchs[k]) + 64'(c)) % 65536);
                        a1 = 32'((64'(vbase[k]) + f1 * 64'(vchs[k]) + 64'(c)) % 65536);
                        s0 = smem[a0];
                        s1 = smem[a1];
                        interp = s0 * 65536 + (s1 - s0) * longint'(frac);
                        acc[c] += interp * longint'(vgain[k]);
                    end
                    vpos[k] = (pos + vstep[k]) & 64'hFF_FFFF_FFFF;
                end
                mask = '0;
                for (int k = 0; k < 8; k++) mask[k] = vplay[k];
                for (int c = 0; c < nch; c++) begin
                    m = acc[c] >>> (16 + svm_pkg::GAIN_BITS);
                    if (m > 8388607) m = 8388607;
                    if (m < -8388608) m = -8388608;
                    o.channel = c[2:0];
                    o.mix_sample = m[23:0];
                    o.last = (c + 1 == nch);
                    o.playing_mask = mask;
                    mix_q = {mix_q, o};
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(svm_pkg::in_word_t w, bit typed = 0,
                             logic signed [23:0] mix0 = 0,
                             logic signed [23:0] mix1 = 0, logic [7:0] mask = 0);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        model_item(w);
        if (typed) begin
            mix_q[$-1].mix_sample = mix0;
            mix_q[$-1].playing_mask = mask;
            mix_q[$].mix_sample = mix1;
            mix_q[$].playing_mask = mask;
        end
        s_data <= w;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid <= 0;
        while (mix_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_out_channels(logic [3:0] n);
        settle();
        cfg_data <= n;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        out_chans = 32'(n);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    function automatic svm_pkg::in_word_t rand_word();
        svm_pkg::in_word_t w;
        w.action = svm_pkg::action_t'($urandom_range(0, 3));
        w.voice = 3'($urandom);
        w.sample_addr = 16'($urandom);
        w.sample_value = 16'($urandom);
        w.clip_base = 16'($urandom);
        w.clip_frames = 17'($urandom);
        w.clip_channels = 4'($urandom);
        w.looping = 1'($urandom);
        w.gain = 16'($urandom);
        w.pitch_step = 24'($urandom);
        w.start_position = $urandom;
        return w;
    endfunction

    // start a voice on a clip whose every word is loaded first
    task automatic start_clip();
        svm_pkg::in_word_t w;
        int unsigned chs, frames, span;
        logic [15:0] a;
        chs = $urandom_range(1, 8);
        frames = $urandom_range(1, 6);
        span = chs * frames;
        w = rand_word();
        for (int i = 0; i < span; i++) begin
            a = w.clip_base + i[15:0];
            if (!swritten[a] || $urandom_range(0, 3) == 0) begin
                svm_pkg::in_word_t ww;
                ww = rand_word();
                ww.action = svm_pkg::ACT_WRITE;
                ww.sample_addr = a;
                case ($urandom_range(0, 5))
                    0: ww.sample_value = 16'sh7FFF;
                    1: ww.sample_value = 16'sh8000;
                    default: ;
                endcase
                send_word(ww);
            end
        end
        w.action = svm_pkg::ACT_START;
        w.clip_frames = 17'(frames);
        w.clip_channels = 4'(chs);
        case ($urandom_range(0, 3))
            0: w.gain = 16'hFFFF;
            1: w.gain = 16'h4000;
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) w.pitch_step = 24'($urandom_range(1, 24'h3FFFF));
        if ($urandom_range(0, 3) != 0)
            w.start_position = $urandom_range(0, (frames << 16) + 24'h1FFFF);
        send_word(w);
    endtask

    task automatic random_phase(int n);
        svm_pkg::in_word_t w;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6: begin
                    w = rand_word();
                    w.action = svm_pkg::ACT_RENDER;
                    send_word(w);
                end
                7, 8, 9, 10: start_clip();
                11, 12: begin
                    w = rand_word();
                    w.action = svm_pkg::ACT_STOP;
                    send_word(w);
                end
                13, 14, 15: begin
                    w = rand_word();
                    w.action = svm_pkg::ACT_WRITE;
                    send_word(w);
                end
                default: begin
                    // broken voice setups that never read memory
                    w = rand_word();
                    w.action = svm_pkg::ACT_START;
                    case ($urandom_range(0, 3))
                        0: w.clip_channels = 0;
                        1: w.clip_frames = 0;
                        2: w.pitch_step = 0;
                        default: begin
                            w.looping = 0;
                            w.clip_frames = 17'($urandom_range(1, 255));
                            w.start_position = $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
                        end
                    endcase
                    send_word(w);
                end
            endcase
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mix_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word ch %0d", m_data.channel));
            end else begin
                svm_pkg::out_word_t e;
                e = mix_q.pop_front();
                words_checked++;
                if (m_data.channel !== e.channel || m_data.mix_sample !== e.mix_sample ||
                    m_data.last !== e.last || m_data.playing_mask !== e.playing_mask)
                    report_mismatch($sformatf(
                        "got ch %0d mix %0d last %0d mask %h, want %0d %0d %0d %h",
                        m_data.channel, m_data.mix_sample, m_data.last, m_data.playing_mask,
                        e.channel, e.mix_sample, e.last, e.playing_mask));
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 0;
                m_ready <= 1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 15)) @(negedge aclk);
                m_ready <= 1;
            end else begin
                m_ready <= 1;
            end
        end
    end

    function automatic stim_row_t row(svm_pkg::action_t act, logic [2:0] v = 0,
                                      logic [15:0] addr = 0,
                                      logic signed [15:0] val = 0, logic [15:0] base = 0,
                                      logic [16:0] frames = 0, logic [3:0] chs = 0,
                                      logic lp = 0, logic [15:0] gain = 0,
                                      logic [23:0] step = 0, logic [31:0] pos = 0);
        stim_row_t r;
        r.w = '{act, v, addr, val, base, frames, chs, lp, gain, step, pos};
        r.typed = 0;
        r.mix0 = 0;
        r.mix1 = 0;
        r.mask = 0;
        return r;
    endfunction

    initial begin
        stim_row_t dir[$];
        stim_row_t r;
        svm_pkg::in_word_t hw;
        logic [3:0] settings[6] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd6};

        repeat (11) @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        r = row(svm_pkg::ACT_RENDER);
        r.typed = 1;
        dir = {dir, r};
        dir = {dir, row(svm_pkg::ACT_WRITE, 0, 16'd0, 16'sh7FFF)};
        dir = {dir, row(svm_pkg::ACT_WRITE, 0, 16'd1, 16'sh8000)};
        dir = {dir, row(svm_pkg::ACT_WRITE, 0, 16'd2, 16'sh1234)};
        dir = {dir, row(svm_pkg::ACT_WRITE, 0, 16'd3, -16'sd1)};
        dir = {dir, row(svm_pkg::ACT_WRITE, 0, 16'hFFFF, 16'sh4000)};
        dir = {dir, row(svm_pkg::ACT_START, 0, 0, 0, 16'd0, 17'd2, 4'd2, 1, 16'h4000,
                        24'h010000, 0)};
        r = row(svm_pkg::ACT_RENDER);
        r.typed = 1;
        r.mix0 = 24'sd32767;
        r.mix1 = -24'sd32768;
        r.mask = 8'h01;
        dir = {dir, r};
        dir = {dir, row(svm_pkg::ACT_START, 1, 0, 0, 16'd0, 17'd2, 4'd2, 1, 16'hFFFF,
                        24'h008000, 32'h0001_8000)};
        dir = {dir, row(svm_pkg::ACT_START, 2, 0, 0, 16'd0, 17'h10000, 4'd0, 1, 16'hFFFF,
                        24'hFFFFFF, 32'hFFFF_FFFF)};
        dir = {dir, row(svm_pkg::ACT_START, 3, 0, 0, 16'd0, 17'd0, 4'd2, 0, 16'h4000,
                        24'h010000, 0)};
        dir = {dir, row(svm_pkg::ACT_START, 4, 0, 0, 16'd0, 17'd2, 4'd2, 1, 16'h4000,
                        24'h0, 0)};
        dir = {dir, row(svm_pkg::ACT_START, 5, 0, 0, 16'd0, 17'd2, 4'd1, 0, 16'h4000,
                        24'h010000, 32'hFFFF_FFFF)};
        dir = {dir, row(svm_pkg::ACT_START, 6, 0, 0, 16'd0, 17'd2, 4'd1, 0, 16'h2000,
                        24'h010000, 32'h0001_8000)};
        dir = {dir, row(svm_pkg::ACT_START, 7, 0, 0, 16'hFFFF, 17'd2, 4'd1, 0, 16'h4000,
                        24'h00C000, 32'h0000_4000)};
        dir = {dir, row(svm_pkg::ACT_RENDER)};
        dir = {dir, row(svm_pkg::ACT_STOP, 7)};
        dir = {dir, row(svm_pkg::ACT_RENDER)};
        dir = {dir, row(svm_pkg::ACT_STOP, 1)};
        dir = {dir, row(svm_pkg::ACT_RENDER)};
        dir = {dir, row(svm_pkg::ACT_RENDER)};

        foreach (dir[i]) send_word(dir[i].w, dir[i].typed, dir[i].mix0, dir[i].mix1, dir[i].mask);

        foreach (settings[p]) begin
            write_out_channels(settings[p]);
            if (p == 0) begin
                // long sink stall with renders queued behind it
                hold_req = 1;
                hw = rand_word();
                hw.action = svm_pkg::ACT_RENDER;
                send_word(hw);
                send_word(hw);
            end
            random_phase(10);
        end
        write_out_channels(4'd2);
        calm = 1;
        random_phase(10);

        settle();
        $display("%0d renders with 1 to 8 output channels, %0d result words checked",
                 renders, words_checked);
        $display("covered loop and one-shot voices, wraps, silent and broken voices, stalls");
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/svm_pkg.sv
rtl/sample_voice_mixer_linear_interp_unit.sv
tb/sv/testbench.sv
